>>> rtl/core/dmic_pkg.sv
// ----------------------------------------------------------------------------
// dmic_pkg
// Shared types, constants and output select codes for the direct-mapped
// instruction cache.
// ----------------------------------------------------------------------------
package dmic_pkg;

   // Address and line geometry
   localparam int unsigned ADDR_BITS          = 32;
   localparam int unsigned WORD_BITS          = 32;
   localparam int unsigned WORDS_PER_LINE     = 8;
   localparam int unsigned WORD_SEL_BITS      = 3;
   localparam int unsigned WORD_LSB           = 2;
   localparam int unsigned OFFSET_BITS        = 5;
   localparam int unsigned TAG_LSB            = 12;
   localparam int unsigned TAG_BITS           = 20;
   localparam int unsigned LINE_COUNT_DEFAULT = 512;

   // Cycle charges reported with results
   localparam logic [5:0] HIT_CYCLES  = 6'd2;
   localparam logic [5:0] MISS_CYCLES = 6'd48;

   // Input item kinds
   localparam logic [1:0] KIND_FETCH  = 2'd0;
   localparam logic [1:0] KIND_PROBE  = 2'd1;
   localparam logic [1:0] KIND_REFILL = 2'd2;

   // Result item kinds
   localparam logic [1:0] RESULT_INSTR   = 2'd0;
   localparam logic [1:0] RESULT_REQUEST = 2'd1;
   localparam logic [1:0] RESULT_REPORT  = 2'd2;

   // Output register source select
   localparam logic [1:0] OUT_HIT_WORD    = 2'd0;
   localparam logic [1:0] OUT_REQUEST     = 2'd1;
   localparam logic [1:0] OUT_REPORT      = 2'd2;
   localparam logic [1:0] OUT_REFILL_WORD = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] refill_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] request_address;
      logic [31:0] instruction;
      logic [5:0]  stall_cycles;
      logic        was_hit;
      logic        last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       clear_wr;
      logic       out_load;
      logic [1:0] out_sel;
      logic       miss_start;
      logic       refill_wr;
      logic       probe_fill;
      logic       req_next;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       hit;
      logic       busy;
      logic       refill_last;
      logic       req_last;
      logic       clear_last;
      logic       out_ready;
   } status_type;

endpackage

>>> rtl/core/dmic_ctrl.sv
// ----------------------------------------------------------------------------
// dmic_ctrl
// Sequencer for the cache: clearing pass, item intake, hit/miss decision and
// read request emission.
// ----------------------------------------------------------------------------
module dmic_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dmic_pkg::status_type stat,
   output dmic_pkg::cmd_type    cmd
);
   import dmic_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_REQ    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (stat.kind)
               KIND_FETCH: begin
                  if (stat.busy) begin
                     state_in = ST_IDLE;
                  end else if (stat.hit) begin
                     if (stat.out_ready) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_HIT_WORD;
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     cmd.miss_start = 1'b1;
                     state_in       = ST_REQ;
                  end
               end
               KIND_PROBE: begin
                  if (stat.out_ready) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_sel    = OUT_REPORT;
                     cmd.probe_fill = !stat.hit;
                     state_in       = ST_IDLE;
                  end
               end
               KIND_REFILL: begin
                  if (!stat.busy) begin
                     state_in = ST_IDLE;
                  end else if (!stat.refill_last) begin
                     cmd.refill_wr = 1'b1;
                     state_in      = ST_IDLE;
                  end else if (stat.out_ready) begin
                     cmd.refill_wr = 1'b1;
                     cmd.out_load  = 1'b1;
                     cmd.out_sel   = OUT_REFILL_WORD;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_REQ: begin
            if (stat.out_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_REQUEST;
               cmd.req_next = 1'b1;
               if (stat.req_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/dmic_datapath.sv
// ----------------------------------------------------------------------------
// dmic_datapath
// Tag and data memories, refill bookkeeping, request counter and the
// registered result stage.
// ----------------------------------------------------------------------------
module dmic_datapath #(
   parameter int unsigned LINE_COUNT = dmic_pkg::LINE_COUNT_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmic_pkg::req_type    req_payload,
   input  dmic_pkg::cmd_type    cmd,
   output dmic_pkg::status_type stat,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output dmic_pkg::rsp_type    rsp_payload
);
   import dmic_pkg::*;

   localparam int unsigned SLOT_BITS = $clog2(LINE_COUNT);
   localparam int unsigned LINE_ADDR_BITS = ADDR_BITS - OFFSET_BITS;

   // Tag store holds the valid flag in its top bit
   logic [TAG_BITS:0]                         tag_mem [LINE_COUNT];
   logic [WORDS_PER_LINE-1:0][WORD_BITS-1:0] data_mem [LINE_COUNT];

   req_type                    item_ff, item_in;
   logic [TAG_BITS:0]          tag_rd_ff;
   logic [WORD_BITS-1:0]       data_rd_ff;
   logic [ADDR_BITS-1:0]       pending_ff, pending_in;
   logic                       busy_ff, busy_in;
   logic [WORD_SEL_BITS-1:0]   count_ff, count_in;
   logic [WORD_SEL_BITS-1:0]   req_idx_ff, req_idx_in;
   logic [SLOT_BITS-1:0]       clear_idx_ff, clear_idx_in;
   logic [WORD_BITS-1:0]       word_cap_ff, word_cap_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [SLOT_BITS-1:0]       rd_slot, item_slot, pend_slot;
   logic [WORD_SEL_BITS-1:0]   rd_word, pend_word;
   logic                       hit;
   logic                       refill_last;
   logic                       out_ready;
   logic                       tag_we;
   logic [SLOT_BITS-1:0]       tag_wa;
   logic [TAG_BITS:0]          tag_wd;

   // Address decode
   assign rd_slot   = req_payload.address[OFFSET_BITS +: SLOT_BITS];
   assign rd_word   = req_payload.address[WORD_LSB +: WORD_SEL_BITS];
   assign item_slot = item_ff.address[OFFSET_BITS +: SLOT_BITS];
   assign pend_slot = pending_ff[OFFSET_BITS +: SLOT_BITS];
   assign pend_word = pending_ff[WORD_LSB +: WORD_SEL_BITS];

   assign hit = tag_rd_ff[TAG_BITS]
             && (tag_rd_ff[TAG_BITS-1:0] == item_ff.address[TAG_LSB +: TAG_BITS]);
   assign refill_last = (count_ff == {WORD_SEL_BITS{1'b1}});
   assign out_ready   = !rsp_valid_ff || !rsp_stall;

   // Status back to the controller
   always_comb begin
      stat.kind        = item_ff.kind;
      stat.hit         = hit;
      stat.busy        = busy_ff;
      stat.refill_last = refill_last;
      stat.req_last    = (req_idx_ff == {WORD_SEL_BITS{1'b1}});
      stat.clear_last  = (clear_idx_ff == SLOT_BITS'(LINE_COUNT - 1));
      stat.out_ready   = out_ready;
   end

   // Tag store write port
   always_comb begin
      tag_we = 1'b0;
      tag_wa = clear_idx_ff;
      tag_wd = '0;
      priority if (cmd.clear_wr) begin
         tag_we = 1'b1;
      end else if (cmd.probe_fill) begin
         tag_we = 1'b1;
         tag_wa = item_slot;
         tag_wd = {1'b1, item_ff.address[TAG_LSB +: TAG_BITS]};
      end else if (cmd.refill_wr && refill_last) begin
         tag_we = 1'b1;
         tag_wa = pend_slot;
         tag_wd = {1'b1, pending_ff[TAG_LSB +: TAG_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
   end

   // Data store: a whole row on the clearing pass, one word on refill
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         data_mem[clear_idx_ff] <= '0;
      end else if (cmd.refill_wr) begin
         data_mem[pend_slot][count_ff] <= item_ff.refill_word;
      end
   end

   // Lookup reads, registered
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tag_rd_ff  <= tag_mem[rd_slot];
         data_rd_ff <= data_mem[rd_slot][rd_word];
      end
   end

   // Item, refill and counter next values
   always_comb begin
      item_in      = cmd.accept ? req_payload : item_ff;
      pending_in   = pending_ff;
      busy_in      = busy_ff;
      count_in     = count_ff;
      req_idx_in   = req_idx_ff;
      word_cap_in  = word_cap_ff;
      clear_idx_in = cmd.clear_wr ? clear_idx_ff + 1'b1 : clear_idx_ff;
      if (cmd.miss_start) begin
         pending_in = item_ff.address;
         busy_in    = 1'b1;
         count_in   = '0;
         req_idx_in = '0;
      end
      if (cmd.req_next) begin
         req_idx_in = req_idx_ff + 1'b1;
      end
      if (cmd.refill_wr) begin
         if (count_ff == pend_word) begin
            word_cap_in = item_ff.refill_word;
         end
         count_in = count_ff + 1'b1;
         if (refill_last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Result stage
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in = '0;
         rsp_in.last = 1'b1;
         unique case (cmd.out_sel)
            OUT_HIT_WORD: begin
               rsp_in.result_kind  = RESULT_INSTR;
               rsp_in.instruction  = data_rd_ff;
               rsp_in.stall_cycles = HIT_CYCLES;
               rsp_in.was_hit      = 1'b1;
            end
            OUT_REQUEST: begin
               rsp_in.result_kind     = RESULT_REQUEST;
               rsp_in.request_address = {pending_ff[ADDR_BITS-1 -: LINE_ADDR_BITS],
                                         req_idx_ff, 2'b00};
               rsp_in.last            = (req_idx_ff == {WORD_SEL_BITS{1'b1}});
            end
            OUT_REPORT: begin
               rsp_in.result_kind  = RESULT_REPORT;
               rsp_in.stall_cycles = hit ? HIT_CYCLES : MISS_CYCLES;
               rsp_in.was_hit      = hit;
            end
            OUT_REFILL_WORD: begin
               rsp_in.result_kind  = RESULT_INSTR;
               rsp_in.instruction  = (count_ff == pend_word) ? item_ff.refill_word
                                                             : word_cap_ff;
               rsp_in.stall_cycles = MISS_CYCLES;
            end
            default: begin
               rsp_in.result_kind = RESULT_INSTR;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         req_idx_ff   <= '0;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         req_idx_ff   <= req_idx_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      word_cap_ff <= word_cap_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/direct_mapped_instruction_cache_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_instruction_cache_unit
// Direct-mapped instruction cache, LINE_COUNT lines of eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries fetches, timing probes and refill words; rsp_* carries
//   instruction words, memory read requests and timing reports. An item
//   moves when valid is high and stall is low.
//   After reset the tag and data stores are swept clear, one line per cycle,
//   and req_stall stays high until all LINE_COUNT lines (512 at the default)
//   are clear. Each input item is first read from the tag and data stores
//   into registers, then decided on, and the decision loads the result
//   register once it is free. req_stall stays high from the taking of an
//   item until the block is done with it, so items are taken one at a time.
//   A fetch miss sends eight read requests, one a cycle while the receiver
//   does not stall, the last one flagged; refill words then come in as input
//   items, and the eighth returns the instruction. Fetches taken while a
//   refill is open give no result. If the receiver stalls, the result
//   register holds its item and the block waits before loading another.
// ----------------------------------------------------------------------------
module direct_mapped_instruction_cache_unit #(
   parameter int unsigned LINE_COUNT = dmic_pkg::LINE_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dmic_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dmic_pkg::rsp_type rsp_payload
);
   import dmic_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // Sequencer
   dmic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Stores and result stage
   dmic_datapath #(
      .LINE_COUNT (LINE_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> bench/tb_direct_mapped_instruction_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_instruction_cache_unit
// Self-checking bench for the direct-mapped instruction cache. A line-level
// model of the tag, valid and data stores predicts every response item. The
// stimulus is a directed run (cold miss and refill, hits, probes, ignored
// items, fetch during an open refill), a back-to-back hit stream, then random
// traffic built mostly from well-formed miss/refill sequences on a small pool
// of conflicting lines. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_direct_mapped_instruction_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dmic_pkg::*;

   localparam int unsigned LINES        = LINE_COUNT_DEFAULT;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;
   localparam int          RANDOM_ITEMS = 225;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 24;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_ALTERNATE
   } stall_style_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Cache image and the response items still owed by the block
   bit          line_present [LINES];
   logic [19:0] line_tag_img [LINES];
   logic [31:0] word_img     [LINES * WORDS_PER_LINE];
   logic [31:0] fill_addr;
   int unsigned fill_count;
   bit          fill_open;
   rsp_type     cache_results_due [$];

   int              errors_seen;
   int              cycle_count;
   int              burst_left;
   bit              sender_gaps_on;
   bit              rsp_stall_on;
   logic [5:0]      stall_phase;
   stall_style_type stall_style;
   logic [31:0]     hot_bases [12];

   direct_mapped_instruction_cache_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic int unsigned line_of(input logic [31:0] a);
      return (a >> 5) % LINES;
   endfunction

   function automatic bit line_hits(input logic [31:0] a);
      return line_present[line_of(a)] && line_tag_img[line_of(a)] == a[31:12];
   endfunction

   function automatic rsp_type make_result(input logic [1:0] kind, input logic [31:0] req,
                                           input logic [31:0] instr, input logic [5:0] cyc,
                                           input logic hit, input logic fin);
      rsp_type r;
      r.result_kind     = kind;
      r.request_address = req;
      r.instruction     = instr;
      r.stall_cycles    = cyc;
      r.was_hit         = hit;
      r.last            = fin;
      return r;
   endfunction

   // Update the cache image for one accepted item, queue what it returns
   task automatic compute_cache_results(input req_type it);
      int unsigned ln;
      logic [31:0] base;
      ln = line_of(it.address);
      case (it.kind)
         KIND_FETCH: begin
            if (!fill_open) begin
               if (line_hits(it.address)) begin
                  cache_results_due.push_back(make_result(RESULT_INSTR, '0,
                     word_img[ln * WORDS_PER_LINE + it.address[4:2]], HIT_CYCLES, 1'b1, 1'b1));
               end else begin
                  base = {it.address[31:5], 5'b0};
                  for (int i = 0; i < WORDS_PER_LINE; i++)
                     cache_results_due.push_back(make_result(RESULT_REQUEST, base + 4 * i,
                        '0, '0, 1'b0, i == WORDS_PER_LINE - 1));
                  fill_addr  = it.address;
                  fill_count = 0;
                  fill_open  = 1'b1;
               end
            end
         end
         KIND_PROBE: begin
            if (line_hits(it.address)) begin
               cache_results_due.push_back(make_result(RESULT_REPORT, '0, '0,
                  HIT_CYCLES, 1'b1, 1'b1));
            end else begin
               line_present[ln] = 1'b1;
               line_tag_img[ln] = it.address[31:12];
               cache_results_due.push_back(make_result(RESULT_REPORT, '0, '0,
                  MISS_CYCLES, 1'b0, 1'b1));
            end
         end
         KIND_REFILL: begin
            if (fill_open) begin
               ln = line_of(fill_addr);
               word_img[ln * WORDS_PER_LINE + fill_count] = it.refill_word;
               if (fill_count != WORDS_PER_LINE - 1) begin
                  fill_count++;
               end else begin
                  fill_count       = 0;
                  fill_open        = 1'b0;
                  line_present[ln] = 1'b1;
                  line_tag_img[ln] = fill_addr[31:12];
                  cache_results_due.push_back(make_result(RESULT_INSTR, '0,
                     word_img[ln * WORDS_PER_LINE + fill_addr[4:2]], MISS_CYCLES, 1'b0, 1'b1));
               end
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- sender
   function automatic req_type make_item(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [31:0] word);
      req_type it;
      it.kind        = kind;
      it.address     = addr;
      it.refill_word = word;
      return it;
   endfunction

   // Present one item, wait for it to be taken, then maybe idle a while.
   // Called right after a rising edge.
   task automatic send_item(input req_type it);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= it;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      compute_cache_results(it);
      if (sender_gaps_on) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 11);
            req_valid   <= 1'b0;
            req_payload <= make_item(2'($urandom_range(0, 3)), $urandom(), $urandom());
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   // Stall style is picked anew at random each time the phase counter wraps
   always @(posedge clock) begin : receiver_pattern
      logic hold;
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd63) stall_style <= stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         STALL_NONE:   hold = 1'b0;
         STALL_RANDOM: hold = ($urandom_range(0, 2) == 0);
         STALL_RUNS:   hold = (stall_phase[4:0] < 5'd12);
         default:      hold = stall_phase[0];
      endcase
      rsp_stall <= hold && rsp_stall_on;
   end

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cache_results_due.size() == 0) begin
            $error("response item with none due: %p", rsp_payload);
            errors_seen++;
         end else begin
            want = cache_results_due.pop_front();
            if (rsp_payload.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d",
                      want.result_kind, rsp_payload.result_kind);
               errors_seen++;
            end
            if (rsp_payload.request_address !== want.request_address) begin
               $error("request_address: expected %h, got %h",
                      want.request_address, rsp_payload.request_address);
               errors_seen++;
            end
            if (rsp_payload.instruction !== want.instruction) begin
               $error("instruction: expected %h, got %h",
                      want.instruction, rsp_payload.instruction);
               errors_seen++;
            end
            if (rsp_payload.stall_cycles !== want.stall_cycles) begin
               $error("stall_cycles: expected %0d, got %0d",
                      want.stall_cycles, rsp_payload.stall_cycles);
               errors_seen++;
            end
            if (rsp_payload.was_hit !== want.was_hit) begin
               $error("was_hit: expected %b, got %b", want.was_hit, rsp_payload.was_hit);
               errors_seen++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_payload.last);
               errors_seen++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** direct_mapped_instruction_cache_unit: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // Cold miss on line 0, refilled with extreme and random words
   task automatic test_cold_miss_refill();
      send_item(make_item(KIND_FETCH, 32'h0000_0004, $urandom()));
      send_item(make_item(KIND_REFILL, $urandom(), 32'h0000_0000));
      send_item(make_item(KIND_REFILL, $urandom(), 32'hffff_ffff));
      for (int i = 2; i < WORDS_PER_LINE; i++)
         send_item(make_item(KIND_REFILL, $urandom(), $urandom()));
   endtask

   task automatic test_hit_and_probe();
      send_item(make_item(KIND_FETCH, 32'h0000_001c, $urandom()));
      send_item(make_item(KIND_PROBE, 32'h0000_0000, $urandom()));
   endtask

   // Probe miss claims the top line without data; a fetch then hits stale words
   task automatic test_probe_fill();
      send_item(make_item(KIND_PROBE, 32'hffff_ffe0, $urandom()));
      send_item(make_item(KIND_FETCH, 32'hffff_fffc, $urandom()));
   endtask

   // Refill with nothing pending and the unused kind: no response
   task automatic test_ignored_items();
      send_item(make_item(KIND_REFILL, 32'hffff_ffff, 32'hffff_ffff));
      send_item(make_item(KIND_UNUSED, 32'hffff_ffff, 32'hffff_ffff));
   endtask

   // Fetch is dropped while a refill is open; a probe to the same line with
   // another tag is served, then the refill completion writes the refill's tag
   task automatic test_fetch_during_refill();
      send_item(make_item(KIND_FETCH, 32'h8000_1008, $urandom()));
      send_item(make_item(KIND_FETCH, 32'h0000_0000, $urandom()));
      send_item(make_item(KIND_PROBE, 32'h8001_1000, $urandom()));
      for (int i = 0; i < WORDS_PER_LINE; i++)
         send_item(make_item(KIND_REFILL, $urandom(), $urandom()));
   endtask

   // Back-to-back hits on the two resident lines, no idling on either side
   task automatic test_streaming_hits();
      logic [31:0] a;
      sender_gaps_on = 1'b0;
      rsp_stall_on   = 1'b0;
      for (int i = 0; i < 30; i++) begin
         a = $urandom_range(0, 1) ? {27'h000_0000, 5'($urandom())}
                                  : {27'h7ff_ffff, 5'($urandom())};
         send_item(make_item((i % 5 == 4) ? KIND_PROBE : KIND_FETCH, a, $urandom()));
      end
      sender_gaps_on = 1'b1;
      rsp_stall_on   = 1'b1;
   endtask

   function automatic logic [31:0] pick_address();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return hot_bases[$urandom_range(0, 11)] | 32'($urandom_range(0, 31));
   endfunction

   // Mostly fetch/refill sequences on a pool of lines that alias each other
   task automatic test_random_traffic();
      int          counted;
      int          pick;
      logic [1:0]  kind;
      bit          effective;
      hot_bases[0] = 32'h0000_0000;
      hot_bases[1] = 32'hffff_ffe0;
      hot_bases[2] = 32'h8000_1000;
      for (int i = 3; i < 8; i++) hot_bases[i] = {27'($urandom()), 5'b0};
      // same index, other tag
      for (int i = 8; i < 12; i++)
         hot_bases[i] = hot_bases[i - 8] ^ {18'($urandom_range(1, 18'h3ffff)), 14'b0};
      counted = 0;
      while (counted < RANDOM_ITEMS || fill_open) begin
         pick = $urandom_range(0, 19);
         if (fill_open) begin
            if (pick < 16) kind = KIND_REFILL;
            else if (pick < 18) kind = KIND_PROBE;
            else if (pick == 18) kind = KIND_FETCH;
            else kind = KIND_UNUSED;
            effective = (kind == KIND_REFILL || kind == KIND_PROBE);
         end else begin
            if (pick < 12) kind = KIND_FETCH;
            else if (pick < 17) kind = KIND_PROBE;
            else if (pick < 19) kind = KIND_REFILL;
            else kind = KIND_UNUSED;
            effective = (kind == KIND_FETCH || kind == KIND_PROBE);
         end
         // once the quota is met, only close out the open refill
         if (counted >= RANDOM_ITEMS) kind = KIND_REFILL;
         send_item(make_item(kind, pick_address(), $urandom()));
         if (effective) counted++;
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      errors_seen    = 0;
      cycle_count    = 0;
      burst_left     = 0;
      sender_gaps_on = 1'b1;
      rsp_stall_on   = 1'b1;
      stall_phase    = '0;
      stall_style    = STALL_NONE;
      fill_addr      = '0;
      fill_count     = 0;
      fill_open      = 1'b0;
      for (int i = 0; i < LINES; i++) begin
         line_present[i] = 1'b0;
         line_tag_img[i] = '0;
      end
      for (int i = 0; i < LINES * WORDS_PER_LINE; i++) word_img[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_cold_miss_refill();
      test_hit_and_probe();
      test_probe_fill();
      test_ignored_items();
      test_fetch_during_refill();
      test_streaming_hits();
      test_random_traffic();

      // let everything owed come out, then watch for strays
      req_valid <= 1'b0;
      while (cache_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors_seen == 0) begin
         $display("** direct_mapped_instruction_cache_unit: PASSED **");
      end else begin
         $display("** direct_mapped_instruction_cache_unit: FAILED **");
      end
      $finish;
   end

endmodule
